// File: rtl/c_token_classifier_assert.svh
// Assertion macros for the C token classifier.
// Used by c_token_classifier; expects clk_i and rst_ni in scope.
`ifndef C_TOKEN_CLASSIFIER_ASSERT_SVH
`define C_TOKEN_CLASSIFIER_ASSERT_SVH

// Checked only while out of reset.
`define CTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define CTC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/ctc_pkg.sv
// Types, constants and character helpers for the C token classifier.
// No dependencies; imported by c_token_classifier.
package ctc_pkg;

  localparam int unsigned LENGTH_LIMIT = 15;
  localparam int unsigned POS_W        = $clog2(LENGTH_LIMIT + 1);
  localparam int unsigned KW_COUNT     = 32;
  localparam int unsigned KW_MAX       = 8;
  localparam int unsigned KW_IDX_W     = $clog2(KW_COUNT);
  localparam int unsigned KW_LEN_W     = $clog2(KW_MAX + 1);

  typedef enum logic [2:0] {
    TT_KEYWORD = 3'd0,
    TT_VAR     = 3'd1,
    TT_LITERAL = 3'd2,
    TT_OP      = 3'd3,
    TT_SEMI    = 3'd4,
    TT_NUM     = 3'd5,
    TT_ERR     = 3'd6
  } tok_kind_e;

  typedef enum logic [2:0] {
    ST_DEC    = 3'd0,
    ST_OCT    = 3'd1,
    ST_HEX    = 3'd2,
    ST_FLOAT  = 3'd3,
    ST_DOUBLE = 3'd4,
    ST_NONE   = 3'd5
  } num_form_e;

  // Keywords, right-justified (last character in the low byte).
  localparam logic [8*KW_MAX-1:0] KW_TABLE [KW_COUNT] = '{
    "auto", "break", "case", "char", "const", "continue", "default", "do",
    "double", "else", "enum", "extern", "float", "for", "goto", "if",
    "int", "long", "register", "return", "short", "signed", "sizeof", "static",
    "struct", "switch", "typedef", "union", "unsigned", "void", "volatile", "while"
  };

  localparam logic [KW_LEN_W-1:0] KW_LEN [KW_COUNT] = '{
    4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd2,
    4'd6, 4'd4, 4'd4, 4'd6, 4'd5, 4'd3, 4'd4, 4'd2,
    4'd3, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd6, 4'd6,
    4'd6, 4'd6, 4'd7, 4'd5, 4'd8, 4'd4, 4'd8, 4'd5
  };

  // Character i of keyword k, zero past its end.
  function automatic logic [7:0] kw_byte(input logic [KW_IDX_W-1:0] k,
                                         input logic [POS_W-1:0] i);
    int          base;
    logic [7:0]  r;
    base = 8 * (int'(KW_LEN[k]) - 1 - int'(i));
    r    = 8'h00;
    if (int'(i) < int'(KW_LEN[k])) begin
      r = KW_TABLE[k][base +: 8];
    end
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= "a") && (c <= "z");
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= "A") && (c <= "Z");
  endfunction

  function automatic logic single_op(input logic [7:0] c);
    logic r;
    unique case (c)
      ".", "-", "*", "&", "!", "~", "/", "%", "+", ">", "<", "^", "|", "=", ",": r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // Two-character operators.
  function automatic logic pair_op(input logic [7:0] a, input logic [7:0] b);
    logic r;
    unique case (a)
      "-":                          r = (b == ">") || (b == "-") || (b == "=");
      "+":                          r = (b == "+") || (b == "=");
      "<":                          r = (b == "<") || (b == "=");
      ">":                          r = (b == ">") || (b == "=");
      "&":                          r = (b == "&") || (b == "=");
      "|":                          r = (b == "|") || (b == "=");
      "=", "!", "/", "*", "%", "^": r = (b == "=");
      default:                      r = 1'b0;
    endcase
    return r;
  endfunction

  // Shift-assign operators, <<= and >>=.
  function automatic logic triple_op(input logic [7:0] a, input logic [7:0] b,
                                     input logic [7:0] c);
    return ((a == "<") || (a == ">")) && (b == a) && (c == "=");
  endfunction

endpackage

// File: rtl/c_token_classifier.sv
// C token classifier: one type/subtype word per token from a character stream.
// Depends on ctc_pkg and c_token_classifier_assert.svh.
// The result word is registered: the word with tlast passes the input register, then the result register.
// Throughput: one character word per cycle, sustained; tokens may follow back to back.
// A token end stalls only while an untaken result word still sits in the output register.
// Reset (rst_ni low, asynchronous) empties both registers and restores the
// per-token state: position 0, stored characters 0, all keywords candidates.
`include "c_token_classifier_assert.svh"

module c_token_classifier (
  input  logic       clk_i,
  input  logic       rst_ni,
  // character stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] ch
  input  logic       s_axis_tlast,   // last character of the token
  // classification stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [2:0] kind, [5:3] number form, [7:6] zero
);
  import ctc_pkg::*;

  // ---------------------------------------------------------------------------
  // Input register: one character word.
  // ---------------------------------------------------------------------------
  logic       in_valid_q;
  logic [7:0] in_ch_q;
  logic       in_last_q;

  // The classify stage moves on unless it holds a token end and the result
  // register is still occupied by an untaken word.
  logic stage_adv;
  logic stage_fire;
  assign stage_adv     = !in_last_q || !m_axis_tvalid || m_axis_tready;
  assign stage_fire    = in_valid_q && stage_adv;
  assign s_axis_tready = !in_valid_q || stage_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_ch_q   <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  // ---------------------------------------------------------------------------
  // Per-token state.
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [7:0]          first_q, first_d;
  logic [7:0]          second_q, second_d;
  logic [7:0]          third_q, third_d;
  logic [KW_COUNT-1:0] cand_q, cand_d;
  logic                dot_q, dot_d;
  logic                fsuf_q, fsuf_d;

  // Values after the current character, before any end-of-token clear.
  logic [POS_W-1:0]    len;
  logic [KW_COUNT-1:0] cand_nxt;
  logic                dot_nxt;
  logic                fsuf_nxt;
  logic [7:0]          c0, c1, c2;
  logic                kw_hit;
  tok_kind_e           type_d;
  num_form_e           sub_d;

  always_comb begin
    c0 = (pos_q == POS_W'(0)) ? in_ch_q : first_q;
    c1 = (pos_q == POS_W'(1)) ? in_ch_q : second_q;
    c2 = (pos_q == POS_W'(2)) ? in_ch_q : third_q;

    // Keyword mask: drop every keyword whose character here differs; a zero byte or a position past KW_MAX drops all.
    for (int k = 0; k < KW_COUNT; k++) begin
      cand_nxt[k] = cand_q[k] && (pos_q < POS_W'(KW_MAX)) && (in_ch_q != 8'h00) &&
                    (kw_byte(KW_IDX_W'(k), pos_q) == in_ch_q);
    end

    dot_nxt  = dot_q || (in_ch_q == ".") || (in_ch_q == "e") || (in_ch_q == "E");
    fsuf_nxt = fsuf_q || (in_ch_q == "f") || (in_ch_q == "F");

    len = (pos_q >= POS_W'(LENGTH_LIMIT)) ? POS_W'(LENGTH_LIMIT) : pos_q + POS_W'(1);

    // A surviving candidate is a keyword if its length equals the token's.
    kw_hit = 1'b0;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (cand_nxt[k] && (POS_W'(KW_LEN[k]) == len)) begin
        kw_hit = 1'b1;
      end
    end
  end

  // Classification of a completed token.
  always_comb begin
    type_d = TT_ERR;
    sub_d  = ST_NONE;
    priority if (len == POS_W'(1)) begin
      priority if (c0 == ";") begin
        type_d = TT_SEMI;
      end else if (single_op(c0)) begin
        type_d = TT_OP;
      end else if (is_digit(c0)) begin
        type_d = TT_NUM;
        sub_d  = ST_DEC;
      end else if (is_lower(c0) || is_upper(c0)) begin
        type_d = TT_VAR;
      end else begin
        type_d = TT_ERR;
      end
    end else if (is_lower(c0)) begin
      type_d = kw_hit ? TT_KEYWORD : TT_VAR;
    end else if (c0 == "0") begin
      type_d = TT_NUM;
      sub_d  = ((len > POS_W'(2)) && ((c1 == "x") || (c1 == "X"))) ? ST_HEX : ST_OCT;
    end else if (is_digit(c0)) begin
      type_d = TT_NUM;
      if (dot_nxt) begin
        sub_d = fsuf_nxt ? ST_FLOAT : ST_DOUBLE;
      end else begin
        sub_d = ST_DEC;
      end
    end else if (((len == POS_W'(2)) && pair_op(c0, c1)) ||
                 ((len == POS_W'(3)) && triple_op(c0, c1, c2))) begin
      type_d = TT_OP;
    end else begin
      type_d = TT_ERR;
    end
  end

  // Next state: accumulate, or restore the empty-token state at a token end.
  always_comb begin
    pos_d    = pos_q;
    first_d  = first_q;
    second_d = second_q;
    third_d  = third_q;
    cand_d   = cand_q;
    dot_d    = dot_q;
    fsuf_d   = fsuf_q;
    if (stage_fire) begin
      if (in_last_q) begin
        pos_d    = '0;
        first_d  = '0;
        second_d = '0;
        third_d  = '0;
        cand_d   = '1;
        dot_d    = 1'b0;
        fsuf_d   = 1'b0;
      end else begin
        pos_d    = len;
        first_d  = c0;
        second_d = c1;
        third_d  = c2;
        cand_d   = cand_nxt;
        dot_d    = dot_nxt;
        fsuf_d   = fsuf_nxt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      first_q  <= '0;
      second_q <= '0;
      third_q  <= '0;
      cand_q   <= '1;
      dot_q    <= 1'b0;
      fsuf_q   <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      first_q  <= first_d;
      second_q <= second_d;
      third_q  <= third_d;
      cand_q   <= cand_d;
      dot_q    <= dot_d;
      fsuf_q   <= fsuf_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------------
  logic        out_valid_q;
  tok_kind_e   out_type_q;
  num_form_e   out_sub_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (stage_fire && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_fire && in_last_q) begin
      out_type_q <= type_d;
      out_sub_q  <= sub_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_sub_q, out_type_q};

  // ---------------------------------------------------------------------------
  // Checks.
  // ---------------------------------------------------------------------------
  `CTC_ASSERT(a_sub_only_for_num, out_valid_q && (out_type_q != TT_NUM) |-> out_sub_q == ST_NONE, "subtype set on a non-number")
  `CTC_ASSERT_ALWAYS(a_pos_saturates, !rst_ni || (pos_q <= POS_W'(LENGTH_LIMIT)), "position past the length limit")
  `CTC_ASSERT(a_clear_after_end, stage_fire && in_last_q |=> (pos_q == '0) && (cand_q == '1), "token state not cleared after token end")
  `CTC_ASSERT(a_no_long_keyword, pos_q > POS_W'(KW_MAX) |-> cand_q == '0, "keyword candidate survives past keyword length")

endmodule

// File: tb/c_token_classifier_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for c_token_classifier: tokens go in one character word
// at a time, each type/subtype word is checked against an in-bench classifier.
// Depends on ctc_pkg (result enums, LENGTH_LIMIT, KW_MAX) and the RTL only.

module c_token_classifier_tb;
  import ctc_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_CHARS = 450;
  localparam int MAX_PRINTS   = 50;

  typedef struct packed {
    tok_kind_e kind;
    num_form_e sub;
  } verdict_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;    // [7:0] ch
  logic       s_axis_tlast;    // last character of the token
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;    // [2:0] kind, [5:3] number form, [7:6] zero

  c_token_classifier dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  string kw_names [32] = '{
    "auto", "break", "case", "char", "const", "continue", "default", "do",
    "double", "else", "enum", "extern", "float", "for", "goto", "if",
    "int", "long", "register", "return", "short", "signed", "sizeof", "static",
    "struct", "switch", "typedef", "union", "unsigned", "void", "volatile", "while"
  };

  // Two-character operators the classifier accepts.
  string op_pairs [19] = '{
    "->", "--", "-=", "++", "+=", "<<", "<=", ">>", ">=", "==",
    "!=", "&&", "&=", "||", "|=", "/=", "*=", "%=", "^="
  };

  localparam string OP_CHARS    = ".-*&!~/%+><^|=,";
  localparam string LOWER_CHARS = "abcdefghijklmnopqrstuvwxyz";
  localparam string UPPER_CHARS = "ABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  localparam string IDENT_CHARS =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
  localparam string DIGITS      = "0123456789";
  localparam string HEX_DIGITS  = "0123456789abcdefABCDEF";

  // Per-token tracking state, mirrors what the block keeps between characters.
  logic [3:0]  tok_len;
  logic [7:0]  ch0, ch1, ch2;
  logic [31:0] kw_alive;
  bit          saw_frac;
  bit          saw_f;

  verdict_t    verdicts_due[$];
  logic [7:0]  tok_buf[$];

  bit          no_gaps;
  int          mismatches;
  int          chars_sent;
  int          tokens_sent;
  int          words_checked;
  int          cycles;

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("[%0t] MISMATCH %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Classifier
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] kw_at(input int k, input int i);
    string s;
    s = kw_names[k];
    if (i < s.len()) return s[i];
    return 8'h00;
  endfunction

  function automatic bit is_dec(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_lc(input logic [7:0] c);
    return c >= "a" && c <= "z";
  endfunction

  function automatic bit is_uc(input logic [7:0] c);
    return c >= "A" && c <= "Z";
  endfunction

  function automatic bit is_op_char(input logic [7:0] c);
    for (int i = 0; i < OP_CHARS.len(); i++) begin
      if (c == OP_CHARS[i]) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit long_op(input int len, input logic [7:0] a, input logic [7:0] b,
                                 input logic [7:0] c);
    if (len == 2) begin
      foreach (op_pairs[i]) begin
        if (a == op_pairs[i][0] && b == op_pairs[i][1]) return 1'b1;
      end
      return 1'b0;
    end
    return len == 3 && (a == "<" || a == ">") && b == a && c == "=";
  endfunction

  function automatic void clear_token();
    tok_len  = '0;
    ch0      = '0;
    ch1      = '0;
    ch2      = '0;
    kw_alive = '1;
    saw_frac = 1'b0;
    saw_f    = 1'b0;
  endfunction

  // Track one accepted character; on the final one, queue the expected word.
  function automatic void classify_char(input logic [7:0] c, input bit fin);
    int       p;
    int       len;
    verdict_t v;
    p = int'(tok_len);
    if (p == 0) ch0 = c;
    else if (p == 1) ch1 = c;
    else if (p == 2) ch2 = c;
    // a zero byte or a position past the longest keyword kills every candidate
    for (int k = 0; k < 32; k++) begin
      if (p >= KW_MAX || c == 8'h00 || kw_at(k, p) != c) kw_alive[k] = 1'b0;
    end
    if (c == "." || c == "e" || c == "E") saw_frac = 1'b1;
    if (c == "f" || c == "F") saw_f = 1'b1;
    len     = (p >= LENGTH_LIMIT) ? LENGTH_LIMIT : p + 1;
    tok_len = len[3:0];
    if (!fin) return;

    v.kind = TT_ERR;
    v.sub  = ST_NONE;
    if (len == 1) begin
      if (ch0 == ";") v.kind = TT_SEMI;
      else if (is_op_char(ch0)) v.kind = TT_OP;
      else if (is_dec(ch0)) begin
        v.kind = TT_NUM;
        v.sub  = ST_DEC;
      end else if (is_lc(ch0) || is_uc(ch0)) v.kind = TT_VAR;
    end else if (is_lc(ch0)) begin
      v.kind = TT_VAR;
      if (len <= KW_MAX) begin
        for (int k = 0; k < 32; k++) begin
          if (kw_alive[k] && kw_at(k, len) == 8'h00) v.kind = TT_KEYWORD;
        end
      end
    end else if (ch0 == "0") begin
      v.kind = TT_NUM;
      v.sub  = (len > 2 && (ch1 == "x" || ch1 == "X")) ? ST_HEX : ST_OCT;
    end else if (ch0 >= "1" && ch0 <= "9") begin
      v.kind = TT_NUM;
      if (saw_frac) v.sub = saw_f ? ST_FLOAT : ST_DOUBLE;
      else v.sub = ST_DEC;
    end else if (long_op(len, ch0, ch1, ch2)) begin
      v.kind = TT_OP;
    end
    verdicts_due.push_back(v);
    clear_token();
  endfunction

  // ---------------------------------------------------------------------------
  // Character sender; called in the time step of a rising edge
  // ---------------------------------------------------------------------------
  task automatic put_char(input logic [7:0] c, input bit fin);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    classify_char(c, fin);
    chars_sent++;
  endtask

  task automatic ship_token();
    for (int i = 0; i < tok_buf.size(); i++) put_char(tok_buf[i], i == tok_buf.size() - 1);
    tokens_sent++;
    tok_buf.delete();
  endtask

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++) tok_buf.push_back(s[i]);
  endfunction

  function automatic logic [7:0] pick_from(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  task automatic send_text(input string s);
    add_text(s);
    ship_token();
  endtask

  // Mostly short tails; now and then one that runs past the length saturation.
  function automatic int tail_len();
    if ($urandom_range(0, 15) == 0) return $urandom_range(12, 24);
    return $urandom_range(0, 6);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stalls, and the checker
  // ---------------------------------------------------------------------------
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    @(posedge clk_i);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      words_checked++;
      if (verdicts_due.size() == 0) begin
        flag_error($sformatf("result word %02h with no token pending", m_axis_tdata));
      end else begin
        want = verdicts_due.pop_front();
        if (m_axis_tdata[2:0] !== want.kind)
          flag_error($sformatf("kind %0d, expected %0d", m_axis_tdata[2:0], want.kind));
        if (m_axis_tdata[5:3] !== want.sub)
          flag_error($sformatf("number form %0d, expected %0d", m_axis_tdata[5:3], want.sub));
        if (m_axis_tdata[7:6] !== 2'b00)
          flag_error($sformatf("pad bits %b, expected 00", m_axis_tdata[7:6]));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[%0t] timeout with %0d words outstanding", $time, verdicts_due.size());
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // One token per class and each corner case.
  task automatic test_directed();
    send_text(";");
    send_text(",");
    send_text("7");
    send_text("q");
    send_text("Z");
    send_text("@");
    send_text("while");
    send_text("continue");
    send_text("registers");           // one past a keyword, nine long
    send_text("wh");
    send_text("Foo");                 // uppercase start is an error
    send_text("_x");
    send_text("0x1f");
    send_text("0x");                  // hex prefix alone stays octal
    send_text("0777");
    send_text("123");
    send_text("3.14");
    send_text("6e2f");
    send_text("<<=");
    send_text("->");
    send_text("<>");
    send_text("abcdefghijklmnopqrstu");          // length count saturates
    send_text("123456789012345678.9F");
    tok_buf.push_back(8'h00);                    // lone zero byte
    ship_token();
    add_text("do");                              // keyword spoiled by a zero byte
    tok_buf.push_back(8'h00);
    ship_token();
    tok_buf.push_back(8'h80);                    // bytes above ASCII
    tok_buf.push_back(8'hff);
    ship_token();
  endtask

  // Every keyword, each followed by a near miss.
  task automatic test_keyword_table();
    string s;
    foreach (kw_names[k]) begin
      s = kw_names[k];
      send_text(s);
      case ($urandom_range(0, 2))
        0: add_text(s.substr(0, s.len() - 2));
        1: begin
          add_text(s);
          tok_buf.push_back(pick_from(IDENT_CHARS));
        end
        default: begin
          add_text(s);
          tok_buf[$urandom_range(1, s.len() - 1)] = pick_from(LOWER_CHARS);
        end
      endcase
      ship_token();
    end
  endtask

  task automatic build_number();
    int n;
    n = tail_len();
    case ($urandom_range(0, 3))
      0: tok_buf.push_back(pick_from("123456789"));
      1: tok_buf.push_back("0");
      2: begin
        tok_buf.push_back("0");
        tok_buf.push_back(pick_from("xX"));
        repeat ($urandom_range(0, 4)) tok_buf.push_back(pick_from(HEX_DIGITS));
        return;
      end
      default: begin
        // real number; sometimes an f suffix with no dot or exponent
        tok_buf.push_back(($urandom_range(0, 7) == 0) ? "0" : pick_from("123456789"));
        repeat ($urandom_range(0, 3)) tok_buf.push_back(pick_from(DIGITS));
        if ($urandom_range(0, 3) != 0) tok_buf.push_back(pick_from(".eE"));
        repeat ($urandom_range(0, 3)) tok_buf.push_back(pick_from(DIGITS));
        if ($urandom_range(0, 1)) tok_buf.push_back(pick_from("fF"));
        return;
      end
    endcase
    repeat (n) tok_buf.push_back(pick_from(DIGITS));
  endtask

  task automatic build_operator();
    case ($urandom_range(0, 4))
      0: tok_buf.push_back(pick_from(OP_CHARS));
      1, 2: add_text(op_pairs[$urandom_range(0, 18)]);
      3: add_text($urandom_range(0, 1) ? "<<=" : ">>=");
      default: repeat ($urandom_range(2, 3)) tok_buf.push_back(pick_from("<>=-+&|!"));
    endcase
  endtask

  task automatic build_random_token();
    int    pick;
    string s;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      add_text(kw_names[$urandom_range(0, 31)]);
    end else if (pick < 25) begin
      s = kw_names[$urandom_range(0, 31)];
      add_text(s);
      case ($urandom_range(0, 2))
        0: void'(tok_buf.pop_back());
        1: tok_buf.push_back(pick_from(IDENT_CHARS));
        default: tok_buf[$urandom_range(1, s.len() - 1)] = 8'h00;
      endcase
    end else if (pick < 40) begin
      tok_buf.push_back(pick_from(LOWER_CHARS));
      repeat (tail_len()) tok_buf.push_back(pick_from(IDENT_CHARS));
    end else if (pick < 48) begin
      tok_buf.push_back(pick_from(UPPER_CHARS));
      repeat (tail_len()) tok_buf.push_back(pick_from(IDENT_CHARS));
    end else if (pick < 63) begin
      build_number();
    end else if (pick < 78) begin
      build_operator();
    end else if (pick < 84) begin
      add_text($urandom_range(0, 4) == 0 ? ";;" : ";");
    end else begin
      // noise over the whole byte range
      repeat ($urandom_range(1, 4) + tail_len()) tok_buf.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random_tokens();
    int start;
    start = chars_sent;
    while (chars_sent - start < RANDOM_CHARS) begin
      // stretches where neither side idles
      if (tokens_sent % 30 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      build_random_token();
      ship_token();
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    no_gaps       = 1'b0;
    mismatches    = 0;
    chars_sent    = 0;
    tokens_sent   = 0;
    words_checked = 0;
    cycles        = 0;
    clear_token();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_keyword_table();
    test_random_tokens();

    s_axis_tvalid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("%0d characters in %0d tokens sent, %0d result words checked, %0d mismatches",
             chars_sent, tokens_sent, words_checked, mismatches);
    $display("covered: directed corners, all keywords with near misses, random tokens with gaps");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
